// ===== sv/mbps_pkg.sv =====
// shared types, constants and register map of the masked byte pattern scanner
package mbps_pkg;

    localparam int MAX_PATTERN_BYTES = 32;
    localparam int PADDR_W           = 6;
    localparam int PDATA_W           = 64;

    // register index codes, paddr[5:3]
    localparam logic [2:0] REG_PAT_WORD_0 = 3'd0;
    localparam logic [2:0] REG_PAT_WORD_1 = 3'd1;
    localparam logic [2:0] REG_PAT_WORD_2 = 3'd2;
    localparam logic [2:0] REG_PAT_WORD_3 = 3'd3;
    localparam logic [2:0] REG_CARE_MASK  = 3'd4;
    localparam logic [2:0] REG_PAT_LENGTH = 3'd5;

    localparam logic [31:0] CARE_MASK_RESET  = 32'hFFFF_FFFF;
    localparam logic [5:0]  PAT_LENGTH_RESET = 6'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       region_end;
    } t_in_req;

    typedef struct packed {
        logic        match_found;
        logic [31:0] match_offset;
    } t_out_req;

    typedef struct packed {
        logic [3:0][63:0] pattern_word;
        logic [31:0]      care_mask;
        logic [5:0]       pattern_length;
    } t_cfg;

endpackage

// ===== sv/mbps_regs.sv =====
// configuration register file behind the apb port
module mbps_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mbps_pkg::PADDR_W-1:0]     paddr,
    input  logic [mbps_pkg::PDATA_W-1:0]     pwdata,
    output logic [mbps_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    output mbps_pkg::t_cfg                   o_cfg
);

    logic [3:0][63:0] r_pat;
    logic [31:0]      r_care;
    logic [5:0]       r_len;
    logic [2:0]       reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_care <= mbps_pkg::CARE_MASK_RESET;
            r_len  <= mbps_pkg::PAT_LENGTH_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                mbps_pkg::REG_PAT_WORD_0: r_pat[0] <= pwdata;
                mbps_pkg::REG_PAT_WORD_1: r_pat[1] <= pwdata;
                mbps_pkg::REG_PAT_WORD_2: r_pat[2] <= pwdata;
                mbps_pkg::REG_PAT_WORD_3: r_pat[3] <= pwdata;
                mbps_pkg::REG_CARE_MASK:  r_care   <= pwdata[31:0];
                mbps_pkg::REG_PAT_LENGTH: r_len    <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            mbps_pkg::REG_PAT_WORD_0: prdata = r_pat[0];
            mbps_pkg::REG_PAT_WORD_1: prdata = r_pat[1];
            mbps_pkg::REG_PAT_WORD_2: prdata = r_pat[2];
            mbps_pkg::REG_PAT_WORD_3: prdata = r_pat[3];
            mbps_pkg::REG_CARE_MASK:  prdata = {32'd0, r_care};
            mbps_pkg::REG_PAT_LENGTH: prdata = {58'd0, r_len};
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg.pattern_word   = r_pat;
    assign o_cfg.care_mask      = r_care;
    assign o_cfg.pattern_length = r_len;

endmodule

// ===== sv/mbps_match.sv =====
// parallel masked compare of the shifted window against the aligned pattern
module mbps_match #(
    parameter int MAX_BYTES = mbps_pkg::MAX_PATTERN_BYTES
) (
    input  mbps_pkg::t_cfg               i_cfg,
    input  logic [MAX_BYTES-1:0][7:0]    i_win,
    output logic [5:0]                   o_len,
    output logic                         o_hit
);

    localparam int PW = MAX_BYTES * 8;

    logic [255:0]         all_pat;
    logic [PW-1:0]        pat;
    logic [PW-1:0]        rev_pat;
    logic [PW-1:0]        al_pat;
    logic [MAX_BYTES-1:0] care;
    logic [MAX_BYTES-1:0] rev_care;
    logic [MAX_BYTES-1:0] al_care;
    logic [5:0]           sh;

    assign all_pat = i_cfg.pattern_word;
    assign pat     = all_pat[PW-1:0];
    assign care    = i_cfg.care_mask[MAX_BYTES-1:0];

    // clamp length into 1..MAX_BYTES
    always_comb begin
        o_len = i_cfg.pattern_length;
        if (o_len == 6'd0) begin
            o_len = 6'd1;
        end
        if (o_len > 6'(MAX_BYTES)) begin
            o_len = 6'(MAX_BYTES);
        end
    end

    // window byte k (0 newest) pairs with pattern byte len-1-k:
    // reverse the pattern, then shift right by MAX_BYTES-len bytes
    always_comb begin
        for (int k = 0; k < MAX_BYTES; k++) begin
            rev_pat[k*8 +: 8] = pat[(MAX_BYTES-1-k)*8 +: 8];
            rev_care[k]       = care[MAX_BYTES-1-k];
        end
    end

    assign sh      = 6'(MAX_BYTES) - o_len;
    assign al_pat  = rev_pat >> {sh, 3'b000};
    assign al_care = rev_care >> sh;

    always_comb begin
        o_hit = 1'b1;
        for (int k = 0; k < MAX_BYTES; k++) begin
            if ((6'(k) < o_len) && al_care[k] && (i_win[k] != al_pat[k*8 +: 8])) begin
                o_hit = 1'b0;
            end
        end
    end

endmodule

// ===== sv/masked_byte_pattern_scanner.sv =====
// top level of the masked byte pattern scanner: input stage, window, result stage
//
//  channel   direction  handshake                              payload
//  in req    in         i_in_req_valid / o_in_req_stall        i_in_req  (data_byte, region_end)
//  out req   out        o_out_req_valid / i_out_req_stall      o_out_req (match_found, match_offset)
//  config    in         psel / penable / pwrite / pready       paddr, pwdata, prdata (64 bit)
//
// one request per cycle sustained while the result slot is not blocked; an accepted request passes
// the input register, then window update and compare into the result register
// the compare of all pattern positions against the shifted window is one pass
// synchronous active-low reset; returns to the pattern reset values and an empty region
// a stalled result holds the result register; the input stage keeps moving as long
// as its request makes no result or the result register is free, otherwise it
// waits and the input channel stalls
module masked_byte_pattern_scanner #(
    parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input request channel
    input  logic                          i_in_req_valid,
    input  mbps_pkg::t_in_req             i_in_req,
    output logic                          o_in_req_stall,
    // result request channel
    output logic                          o_out_req_valid,
    output mbps_pkg::t_out_req            o_out_req,
    input  logic                          i_out_req_stall,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mbps_pkg::PADDR_W-1:0]  paddr,
    input  logic [mbps_pkg::PDATA_W-1:0]  pwdata,
    output logic [mbps_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    mbps_pkg::t_cfg cfg;

    // input stage
    logic               r_in_v;
    mbps_pkg::t_in_req  r_in;
    // region state
    logic [MAX_PATTERN_BYTES-1:0][7:0] r_win;
    logic [MAX_PATTERN_BYTES-1:0][7:0] n_win;
    logic [31:0]        r_seen;
    logic [31:0]        n_seen;
    logic               r_found;
    // result stage
    logic               r_out_v;
    mbps_pkg::t_out_req r_out;

    logic        in_acc;
    logic        out_acc;
    logic        adv;
    logic        produce;
    logic        hit;
    logic        match_ok;
    logic [5:0]  act_len;

    mbps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // window as it looks after taking the staged byte, entry 0 newest
    always_comb begin
        n_win[0] = r_in.data_byte;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
            n_win[k] = r_win[k-1];
        end
    end

    mbps_match #(
        .MAX_BYTES (MAX_PATTERN_BYTES)
    ) u_match (
        .i_cfg (cfg),
        .i_win (n_win),
        .o_len (act_len),
        .o_hit (hit)
    );

    // saturating byte count including the staged byte
    assign n_seen = (r_seen == 32'hFFFF_FFFF) ? r_seen : r_seen + 32'd1;

    // a match needs a full pattern's worth of bytes from this region, so
    // stale window entries from earlier regions never take part
    assign match_ok = (n_seen >= {26'd0, act_len}) && hit;
    assign produce  = !r_found && (match_ok || r_in.region_end);

    // the staged request moves on unless it has a result and the result slot is blocked
    assign adv     = r_in_v && (!produce || !r_out_v || !i_out_req_stall);
    assign out_acc = r_out_v && !i_out_req_stall;

    assign o_in_req_stall = r_in_v && !adv;
    assign in_acc         = i_in_req_valid && !o_in_req_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (in_acc) begin
            r_in_v <= 1'b1;
        end else if (adv) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_req;
        end
    end

    // window only shifts while still searching
    always_ff @(posedge i_clk) begin
        if (adv && !r_found) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_found <= 1'b0;
        end else if (adv) begin
            if (r_in.region_end) begin
                // region done, start clean
                r_seen  <= '0;
                r_found <= 1'b0;
            end else if (!r_found) begin
                r_seen  <= n_seen;
                r_found <= match_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv && produce) begin
            r_out_v <= 1'b1;
        end else if (out_acc) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && produce) begin
            r_out.match_found  <= match_ok;
            r_out.match_offset <= match_ok ? (n_seen - {26'd0, act_len}) : 32'd0;
        end
    end

    assign o_out_req_valid = r_out_v;
    assign o_out_req       = r_out;

    // staged request is never overwritten before it moves on
    a_in_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_in_v) |-> adv)
        else $error("input stage overwritten");

    // a held result is never replaced while stalled
    a_out_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && produce && r_out_v) |-> !i_out_req_stall)
        else $error("result register overwritten");

    // end of region leaves a clean state
    a_region_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.region_end) |=> (r_seen == 32'd0 && !r_found))
        else $error("region state not cleared");

    // no second result once a match has been reported
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_found) |-> !produce)
        else $error("result after match");

    // a reported match lies inside the bytes seen up to the matching byte
    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && produce && match_ok) |=>
            (r_out.match_found && r_out.match_offset < $past(n_seen)))
        else $error("match offset out of range");

endmodule

// ===== test/tb_masked_byte_pattern_scanner.sv =====
// testbench of the masked byte pattern scanner: directed and random regions against a predictor
module tb_masked_byte_pattern_scanner;
    timeunit 1ns;
    timeprecision 1ps;

    // settle time after the last expected result, past the input and result registers
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 200;

    // addresses past the register map, writes there must change nothing
    localparam logic [2:0] REG_UNUSED_6 = 3'd6;
    localparam logic [2:0] REG_UNUSED_7 = 3'd7;
    localparam logic [2:0] WORD_REGS [4] = '{mbps_pkg::REG_PAT_WORD_0, mbps_pkg::REG_PAT_WORD_1,
                                             mbps_pkg::REG_PAT_WORD_2, mbps_pkg::REG_PAT_WORD_3};

    logic                          i_clk;
    logic                          i_rst_n         = 1'b0;
    logic                          i_in_req_valid  = 1'b0;
    mbps_pkg::t_in_req             i_in_req        = '0;
    logic                          o_in_req_stall;
    logic                          o_out_req_valid;
    mbps_pkg::t_out_req            o_out_req;
    logic                          i_out_req_stall = 1'b0;
    logic                          psel            = 1'b0;
    logic                          penable         = 1'b0;
    logic                          pwrite          = 1'b0;
    logic [mbps_pkg::PADDR_W-1:0]  paddr           = '0;
    logic [mbps_pkg::PDATA_W-1:0]  pwdata          = '0;
    logic [mbps_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    masked_byte_pattern_scanner uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_req_valid  (i_in_req_valid),
        .i_in_req        (i_in_req),
        .o_in_req_stall  (o_in_req_stall),
        .o_out_req_valid (o_out_req_valid),
        .o_out_req       (o_out_req),
        .i_out_req_stall (i_out_req_stall),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // mirror of the configuration registers, at their reset values
    logic [63:0] pat_word [4] = '{default: '0};
    logic [31:0] care_bits    = mbps_pkg::CARE_MASK_RESET;
    logic [5:0]  pat_len      = mbps_pkg::PAT_LENGTH_RESET;

    // scan state of the current region
    logic [7:0]  recent_bytes [32] = '{default: '0};
    logic [31:0] region_count      = '0;
    bit          match_reported    = 1'b0;

    mbps_pkg::t_out_req expected_results [$];

    int mismatch_count = 0;
    int n_requests     = 0;
    int n_matches      = 0;
    int n_misses       = 0;
    int n_cfg_writes   = 0;

    // idling controls, percent per cycle (receiver) or per request (sender)
    int gap_pct   = 0;
    int stall_pct = 0;

    // a toggle here starts one long receiver hold-off
    bit hold_trigger = 1'b0;
    bit hold_seen    = 1'b0;
    int hold_left    = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("masked_byte_pattern_scanner test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // pattern length in use: zero counts as one, anything above the maximum is clamped
    function automatic int unsigned active_len();
        if (pat_len == 0) return 1;
        if (pat_len > mbps_pkg::MAX_PATTERN_BYTES) return mbps_pkg::MAX_PATTERN_BYTES;
        return pat_len;
    endfunction

    function automatic logic [7:0] pattern_byte(input int unsigned j);
        return pat_word[2'(j >> 3)][(j & 7) * 8 +: 8];
    endfunction

    // advance the region by one byte; returns 1 when the byte makes a result
    function automatic bit scan_byte(input mbps_pkg::t_in_req req,
                                     output mbps_pkg::t_out_req res);
        int unsigned eff_len;
        int          k;
        bit          hit;
        bit          produced;
        produced = 1'b0;
        res      = '0;
        if (!match_reported) begin
            eff_len = active_len();
            for (k = 31; k > 0; k--) recent_bytes[k] = recent_bytes[k - 1];
            recent_bytes[0] = req.data_byte;
            if (region_count != 32'hFFFF_FFFF) region_count++;
            // newest byte is entry 0, so pattern byte 0 lines up with the oldest in the window
            hit = (region_count >= eff_len);
            for (k = 0; k < eff_len && hit; k++) begin
                if (care_bits[k] && recent_bytes[eff_len - 1 - k] != pattern_byte(k)) hit = 1'b0;
            end
            if (hit) begin
                match_reported   = 1'b1;
                res.match_found  = 1'b1;
                res.match_offset = region_count - eff_len;
                produced         = 1'b1;
            end else if (req.region_end) begin
                produced = 1'b1;
            end
        end
        if (req.region_end) begin
            recent_bytes   = '{default: '0};
            region_count   = '0;
            match_reported = 1'b0;
        end
        return produced;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        mbps_pkg::t_out_req want;
        if (i_rst_n && o_out_req_valid && !i_out_req_stall) begin
            if (o_out_req.match_found) n_matches++;
            else n_misses++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got found=%0b offset=%0d",
                         $time, o_out_req.match_found, o_out_req.match_offset);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_req.match_found !== want.match_found) begin
                    $display("%0t: match_found mismatch, expected %0b, got %0b",
                             $time, want.match_found, o_out_req.match_found);
                    mismatch_count++;
                end
                if (o_out_req.match_offset !== want.match_offset) begin
                    $display("%0t: match_offset mismatch, expected %0d, got %0d",
                             $time, want.match_offset, o_out_req.match_offset);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver: random stalls, or one long hold-off when triggered
    always @(posedge i_clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_req_stall <= 1'b1;
        end else begin
            i_out_req_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one request, possibly after an idle gap, and wait until it is taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        mbps_pkg::t_in_req  req;
        mbps_pkg::t_out_req res;
        req.data_byte  = b;
        req.region_end = last;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            i_in_req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_req_valid <= 1'b1;
        i_in_req       <= req;
        do @(posedge i_clk); while (o_in_req_stall);
        n_requests++;
        if (scan_byte(req, res)) expected_results.push_back(res);
    endtask

    // drop valid, wait for every expected result, then let the pipeline settle
    task automatic wait_idle();
        i_in_req_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // setup then access cycle; psel stays up between writes of one burst and
    // the next write's setup drops penable
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val, input bit end_burst);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (end_burst) begin
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
        end
        n_cfg_writes++;
        case (idx)
            mbps_pkg::REG_PAT_WORD_0, mbps_pkg::REG_PAT_WORD_1,
            mbps_pkg::REG_PAT_WORD_2, mbps_pkg::REG_PAT_WORD_3: pat_word[idx[1:0]] = val;
            mbps_pkg::REG_CARE_MASK:                            care_bits = val[31:0];
            mbps_pkg::REG_PAT_LENGTH:                           pat_len = val[5:0];
            default: ;
        endcase
    endtask

    task automatic randomize_config();
        logic [63:0] word;
        int          k;
        for (k = 0; k < 4; k++) begin
            case ($urandom_range(9))
                0:       word = '0;
                1:       word = '1;
                default: word = {$urandom, $urandom};
            endcase
            write_reg(WORD_REGS[k], word, 1'b0);
        end
        case ($urandom_range(7))
            0, 1:    word = 64'hFFFF_FFFF;
            2:       word = '0;
            default: word = 64'($urandom);
        endcase
        write_reg(mbps_pkg::REG_CARE_MASK, word, 1'b0);
        // mostly short patterns, a few long ones and the clamped values
        case ($urandom_range(19))
            0:                word = '0;
            1:                word = 64'($urandom_range(33, 63));
            2, 3:             word = 64'($urandom_range(17, 32));
            4, 5, 6, 7, 8, 9: word = 64'($urandom_range(5, 16));
            default:          word = 64'($urandom_range(1, 4));
        endcase
        write_reg(mbps_pkg::REG_PAT_LENGTH, word, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset pattern is one zero byte that must match
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b1);             // match on the last byte
        send_byte(8'hFF, 1'b1);             // no match
        wait_idle();
    endtask

    task automatic test_length_clamp();
        write_reg(mbps_pkg::REG_PAT_WORD_0, 64'h0000_0000_0000_00AB, 1'b0);
        write_reg(mbps_pkg::REG_PAT_LENGTH, 64'd0, 1'b1);     // zero behaves as one
        send_byte(8'h12, 1'b0);
        send_byte(8'hAB, 1'b1);
        wait_idle();
        // too large clamps to the maximum, region shorter than the pattern
        write_reg(mbps_pkg::REG_PAT_LENGTH, 64'd63, 1'b1);
        send_byte(8'hAB, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_idle();
    endtask

    // middle byte is a wildcard; bytes after the match and the region end stay silent
    task automatic test_wildcards();
        write_reg(mbps_pkg::REG_PAT_WORD_0, 64'h0000_0000_0043_3F41, 1'b0);
        write_reg(mbps_pkg::REG_CARE_MASK, 64'h0000_0005, 1'b0);
        write_reg(mbps_pkg::REG_PAT_LENGTH, 64'd3, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'h77, 1'b0);
        send_byte(8'h43, 1'b0);
        send_byte(8'h44, 1'b0);
        send_byte(8'h45, 1'b1);
        wait_idle();
    endtask

    // pattern changes while a region is open, takes effect from the next byte
    task automatic test_config_mid_region();
        write_reg(mbps_pkg::REG_PAT_WORD_0, 64'h0000_0000_0000_2211, 1'b0);
        write_reg(mbps_pkg::REG_CARE_MASK, 64'hFFFF_FFFF, 1'b0);
        write_reg(mbps_pkg::REG_PAT_LENGTH, 64'd2, 1'b1);
        send_byte(8'h11, 1'b0);
        wait_idle();
        write_reg(mbps_pkg::REG_PAT_WORD_0, 64'h0000_0000_0000_2233, 1'b1);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h22, 1'b1);
        wait_idle();
    endtask

    // writes past the map must leave the pattern alone
    task automatic test_unused_registers();
        write_reg(REG_UNUSED_6, '1, 1'b0);
        write_reg(REG_UNUSED_7, '0, 1'b1);
        send_byte(8'h33, 1'b0);
        send_byte(8'h22, 1'b1);
        wait_idle();
    endtask

    // every one-byte region reports, receiver holds off so results back up into the input
    task automatic test_backpressure();
        int k;
        gap_pct   = 0;
        stall_pct = 0;
        write_reg(mbps_pkg::REG_CARE_MASK, 64'h0, 1'b0);
        write_reg(mbps_pkg::REG_PAT_LENGTH, 64'd1, 1'b1);
        hold_trigger = ~hold_trigger;
        for (k = 0; k < 60; k++) send_byte(8'($urandom), 1'b1);
        wait_idle();
    endtask

    // regions mostly carry the pattern (wildcards filled at random), some with one
    // byte of the placed pattern broken (cared or not), the rest filler drawn from random bytes and pattern bytes
    task automatic test_random_phase(input int gap, input int stall, input int n_bytes);
        logic [7:0] region_bytes [$];
        int         eff;
        int         span;
        int         at;
        int         k;
        int         start_count;
        gap_pct     = gap;
        stall_pct   = stall;
        start_count = n_requests;
        while (n_requests - start_count < n_bytes) begin
            if ($urandom_range(3) == 0) begin
                wait_idle();
                randomize_config();
            end
            eff = active_len();
            region_bytes.delete();
            span = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, eff + 10);
            for (k = 0; k < span; k++) begin
                region_bytes.push_back($urandom_range(1) ? 8'($urandom)
                                                         : pattern_byte($urandom_range(eff - 1)));
            end
            if (span >= eff && $urandom_range(9) < 7) begin
                at = $urandom_range(span - eff);
                for (k = 0; k < eff; k++) begin
                    if (care_bits[k]) region_bytes[at + k] = pattern_byte(k);
                end
                if ($urandom_range(4) == 0) begin
                    k = at + $urandom_range(eff - 1);
                    region_bytes[k] = region_bytes[k] ^ (8'h01 << $urandom_range(7));
                end
            end
            for (k = 0; k < span; k++) send_byte(region_bytes[k], k == span - 1);
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_length_clamp();
        test_wildcards();
        test_config_mid_region();
        test_unused_registers();
        test_random_phase(0, 0, 325);       // no idling
        test_backpressure();
        test_random_phase(45, 0, 325);      // sender gaps
        test_random_phase(0, 45, 325);      // receiver stalls
        test_random_phase(19, 19, 325);     // both

        wait_idle();
        $display("run covered %0d requests, %0d matches and %0d not-found results",
                 n_requests, n_matches, n_misses);
        $display("with %0d register writes across directed, random and hold-off phases",
                 n_cfg_writes);
        if (mismatch_count == 0) begin
            $display("masked_byte_pattern_scanner test passed");
        end else begin
            $display("masked_byte_pattern_scanner test failed");
        end
        $finish;
    end

endmodule
